// ===== design/ibst_map_pkg.sv =====
// Shared types and codes for the array-based search tree map.
`default_nettype none
package ibst_map_pkg;

	localparam int COUNT_W = 10;

	localparam logic [1:0] MODE_GET    = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;
	localparam logic [1:0] MODE_DELETE = 2'd3;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_UPDATED   = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [31:0]        read_value;
		logic               was_deleted;
		logic [COUNT_W-1:0] item_count;
	} result_t;

endpackage
`default_nettype wire

// ===== design/implicit_array_bst_map.sv =====
// A transaction visits one tree level per cycle; the result strobe is registered and comes in the cycle
// after the last level read.
// Busy drops in the result cycle, so a new transaction is taken only after the last one ends;
// the single read port of the slot memory is read once per level.
// Reset: a clearing pass writes every slot while busy is high.
// The receiver cannot stall; each result is marked by a done strobe shown for exactly one cycle.
`default_nettype none
module implicit_array_bst_map #(
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32,
	parameter int TREE_LEVELS = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire ibst_map_pkg::request_t  request,
	output logic                         done,
	output ibst_map_pkg::result_t        result
);

	import ibst_map_pkg::*;

	localparam int ADDR_W = TREE_LEVELS;
	localparam int DEPTH  = 1 << TREE_LEVELS;
	localparam int WORD_W = KEY_BITS + VALUE_BITS + 2;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;

	logic [1:0]            state_q;
	logic [ADDR_W-1:0]     idx_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [COUNT_W-1:0]    count_q;
	logic [1:0]            mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  done_q;
	result_t               result_q;

	logic                  accept;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [WORD_W-1:0]     mem_wdata;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [WORD_W-1:0]     rd_data;

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  rd_used;
	logic                  rd_erased;
	logic                  hit;
	logic                  go_right;
	logic [ADDR_W:0]       next_idx;
	logic                  walk_end;
	logic [COUNT_W-1:0]    count_d;
	result_t               res_d;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Slot word layout: {erased, used, value, key}.
	assign rd_key    = rd_data[KEY_BITS-1:0];
	assign rd_val    = rd_data[KEY_BITS +: VALUE_BITS];
	assign rd_used   = rd_data[WORD_W-2];
	assign rd_erased = rd_data[WORD_W-1];

	assign hit      = rd_used && (rd_key == key_q);
	assign go_right = rd_key < key_q;
	assign next_idx = {idx_q, go_right};
	// The walk stops at an empty slot, at a match, or when the child lies past the table.
	assign walk_end = !rd_used || hit || next_idx[ADDR_W];

	always_comb begin
		mem_raddr = ADDR_W'(1);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_data;
		count_d   = count_q;
		res_d.status      = ST_NOT_FOUND;
		res_d.read_value  = '0;
		res_d.was_deleted = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_WALK: begin
				mem_raddr = next_idx[ADDR_W-1:0];
				if (walk_end) begin
					case (mode_q)
						MODE_GET: begin
							if (hit) begin
								res_d.status      = ST_FOUND;
								res_d.read_value  = 32'(rd_val);
								res_d.was_deleted = rd_erased;
							end
						end
						MODE_INSERT: begin
							if (hit) begin
								mem_we    = 1'b1;
								mem_wdata = {rd_erased, 1'b1, val_q, rd_key};
								res_d.status = ST_UPDATED;
							end else if (!rd_used) begin
								mem_we    = 1'b1;
								mem_wdata = {1'b0, 1'b1, val_q, key_q};
								count_d   = count_q + 1'b1;
								res_d.status = ST_INSERTED;
							end else begin
								res_d.status = ST_FULL;
							end
						end
						MODE_UPDATE: begin
							if (hit) begin
								mem_we    = 1'b1;
								mem_wdata = {rd_erased, 1'b1, val_q, rd_key};
								res_d.status = ST_UPDATED;
							end
						end
						default: begin
							if (hit) begin
								mem_we    = 1'b1;
								mem_wdata = {1'b1, 1'b1, rd_val, rd_key};
								res_d.status = ST_DELETED;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		res_d.item_count = count_d;
	end

	ibst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_end) begin
						state_q <= S_IDLE;
						count_q <= count_d;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= request.mode;
			key_q  <= KEY_BITS'(request.key);
			val_q  <= VALUE_BITS'(request.value);
			idx_q  <= ADDR_W'(1);
		end else if (state_q == S_WALK) begin
			idx_q <= next_idx[ADDR_W-1:0];
		end
		if (state_q == S_WALK && walk_end) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_WALK)
		else $error("result strobe without a finished walk");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_INSERTED) |->
		result.item_count == COUNT_W'($past(count_q) + 1'b1))
		else $error("insert did not advance the item count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("slot memory written while idle");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done)
		else $error("item count changed without a transaction result");
`endif

endmodule
`default_nettype wire

// ===== design/ibst_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module ibst_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the array-based search tree map, with a shadow copy of the slots.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibst_map_pkg::*;

	localparam int TREE_LEVELS = 10;
	localparam int SLOTS = 1 << TREE_LEVELS;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		request_t    req;
		int unsigned gap;
		bit          wait_for_drain;
	} queued_request_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     done;
	result_t  result;

	queued_request_t requests_to_send[$];
	queued_request_t next_request;
	result_t         map_answers[$];
	result_t         oldest_answer;
	logic [31:0]     placed_keys[$];
	int unsigned     hold_cycles = 0;
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count = 0;

	// Shadow copy of the tree slots.
	logic [31:0]        shadow_key[0:SLOTS-1];
	logic [31:0]        shadow_val[0:SLOTS-1];
	bit                 shadow_used[0:SLOTS-1];
	bit                 shadow_erased[0:SLOTS-1];
	logic [COUNT_W-1:0] shadow_total = '0;

	implicit_array_bst_map #(
		.KEY_BITS(32),
		.VALUE_BITS(32),
		.TREE_LEVELS(TREE_LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #4ns clk = ~clk;

	// Walks the shadow tree, applies the operation and returns the answer the block owes.
	function automatic result_t map_operation(input request_t r);
		result_t     ans;
		int unsigned slot;
		bit          found;
		bit          in_table;
		slot = 1;
		found = 1'b0;
		while (slot < SLOTS && shadow_used[slot] && !found) begin
			if (shadow_key[slot] == r.key)
				found = 1'b1;
			else
				slot = 2 * slot + ((shadow_key[slot] < r.key) ? 1 : 0);
		end
		in_table = slot < SLOTS;
		ans = '0;
		ans.status = ST_NOT_FOUND;
		case (r.mode)
			MODE_GET: begin
				if (found) begin
					ans.status = ST_FOUND;
					ans.read_value = shadow_val[slot];
					ans.was_deleted = shadow_erased[slot];
				end
			end
			MODE_INSERT: begin
				if (found) begin
					shadow_val[slot] = r.value;
					ans.status = ST_UPDATED;
				end else if (in_table) begin
					shadow_key[slot] = r.key;
					shadow_val[slot] = r.value;
					shadow_used[slot] = 1'b1;
					shadow_erased[slot] = 1'b0;
					shadow_total = shadow_total + 1'b1;
					ans.status = ST_INSERTED;
				end else begin
					ans.status = ST_FULL;
				end
			end
			MODE_UPDATE: begin
				if (found) begin
					shadow_val[slot] = r.value;
					ans.status = ST_UPDATED;
				end
			end
			default: begin
				if (found) begin
					shadow_erased[slot] = 1'b1;
					ans.status = ST_DELETED;
				end
			end
		endcase
		ans.item_count = shadow_total;
		return ans;
	endfunction

	task automatic add_request(input logic [1:0] mode, input logic [31:0] key,
			input logic [31:0] value, input bit drain, input bit no_idle);
		queued_request_t q;
		int unsigned     r;
		r = $urandom_range(99);
		q.req.mode = mode;
		q.req.key = key;
		q.req.value = value;
		q.wait_for_drain = drain;
		if (no_idle || r < 60)
			q.gap = 0;
		else if (r < 88)
			q.gap = $urandom_range(3, 1);
		else if (r < 97)
			q.gap = $urandom_range(12, 4);
		else
			q.gap = $urandom_range(60, 20);
		requests_to_send.push_back(q);
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Driver: presents queued requests, holds each until the transaction is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				map_answers.push_back(map_operation(request));
			if (start && busy) begin
				start <= 1'b1;
			end else if (requests_to_send.size() == 0) begin
				start <= 1'b0;
			end else if (hold_cycles != 0) begin
				hold_cycles = hold_cycles - 1;
				start <= 1'b0;
			end else if (requests_to_send[0].wait_for_drain && (map_answers.size() != 0 || busy)) begin
				start <= 1'b0;
			end else begin
				next_request = requests_to_send.pop_front();
				start <= 1'b1;
				request <= next_request.req;
				hold_cycles = (requests_to_send.size() != 0) ? requests_to_send[0].gap : 0;
			end
		end
	end

	// Monitor: every strobed result is matched against the oldest outstanding answer.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (map_answers.size() == 0) begin
				flag_mismatch("result with no transaction outstanding", 32'(result.status),
					32'h0);
			end else begin
				oldest_answer = map_answers.pop_front();
				if (result.status !== oldest_answer.status)
					flag_mismatch("status", 32'(result.status), 32'(oldest_answer.status));
				if (result.read_value !== oldest_answer.read_value)
					flag_mismatch("read_value", result.read_value, oldest_answer.read_value);
				if (result.was_deleted !== oldest_answer.was_deleted)
					flag_mismatch("was_deleted", 32'(result.was_deleted),
						32'(oldest_answer.was_deleted));
				if (result.item_count !== oldest_answer.item_count)
					flag_mismatch("item_count", 32'(result.item_count),
						32'(oldest_answer.item_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int          j;
		int          n;
		int unsigned r;
		bit          no_idle;
		bit          fresh;
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] value;

		// Empty tree: every lookup ends at the empty root.
		add_request(MODE_GET, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 1'b0);
		add_request(MODE_UPDATE, 32'h1234_5678, 32'hAAAA_5555, 1'b0, 1'b0);
		add_request(MODE_DELETE, 32'h1234_5678, 32'h0, 1'b0, 1'b0);
		// A mid-range root, then a right-leaning chain that fills all ten levels.
		add_request(MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		placed_keys.push_back(32'h8000_0000);
		for (j = 0; j < 8; j++) begin
			key = 32'hF000_0000 + j * 32'h1000;
			add_request(MODE_INSERT, key, $urandom, 1'b0, 1'b0);
			placed_keys.push_back(key);
		end
		add_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		placed_keys.push_back(32'hFFFF_FFFF);
		// This key walks off the bottom of the chain.
		add_request(MODE_INSERT, 32'hF001_0000, 32'h5A5A_5A5A, 1'b0, 1'b0);
		add_request(MODE_GET, 32'hF001_0000, 32'h0, 1'b0, 1'b0);
		add_request(MODE_DELETE, 32'hF001_0000, 32'h0, 1'b0, 1'b0);
		// Deleted marks survive repeat deletes and inserts over the same key.
		add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		add_request(MODE_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		add_request(MODE_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		add_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h1357_9BDF, 1'b0, 1'b0);
		add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		add_request(MODE_INSERT, 32'h0, 32'h0, 1'b0, 1'b0);
		placed_keys.push_back(32'h0);
		add_request(MODE_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		add_request(MODE_GET, 32'h0, 32'h0, 1'b0, 1'b0);

		// Random part: roughly half the keys reuse ones already placed so that walks can hit.
		for (n = 0; n < 530; n++) begin
			no_idle = ((n / 50) % 3) == 1;
			r = $urandom_range(99);
			if (r < 35)
				mode = MODE_INSERT;
			else if (r < 65)
				mode = MODE_GET;
			else if (r < 80)
				mode = MODE_UPDATE;
			else
				mode = MODE_DELETE;
			fresh = !$urandom_range(1);
			if (!fresh) begin
				key = placed_keys[$urandom_range(placed_keys.size() - 1)];
			end else begin
				r = $urandom_range(19);
				if (r == 0)
					key = 32'h0;
				else if (r == 1)
					key = 32'hFFFF_FFFF;
				else if (r == 2)
					key = 32'hF000_0000 + $urandom_range(32'h0001_FFFF);
				else
					key = $urandom;
				if (mode == MODE_INSERT)
					placed_keys.push_back(key);
			end
			r = $urandom_range(9);
			if (r == 0)
				value = 32'h0;
			else if (r == 1)
				value = 32'hFFFF_FFFF;
			else
				value = $urandom;
			add_request(mode, key, value, n == 0 || n == 300, no_idle);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_to_send.size() != 0 || start || map_answers.size() != 0)
			@(posedge clk);
		repeat (TREE_LEVELS + 6) @(posedge clk);

		if (mismatch_count == 0 && map_answers.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
